/* rtl/zpdf_pkg.sv */
// Shared types and constants for the zero padded decimal formatter.
// Used by every file of the block; depends on nothing.
package zpdf_pkg;

   // Defaults for the top level parameters
   localparam int DEF_MAX_WIDTH  = 63;
   localparam int DEF_VALUE_BITS = 32;

   // Fixed field widths
   localparam int VALUE_FIELD_BITS = 32;
   localparam int WIDTH_BITS       = 6;
   localparam int CHAR_BITS        = 8;

   // Double dabble shifts handled per conversion stage
   localparam int BITS_PER_STAGE = 8;

   // ASCII codes
   localparam logic [CHAR_BITS-1:0] ASCII_ZERO  = 8'd48;
   localparam logic [CHAR_BITS-1:0] ASCII_MINUS = 8'd45;

   // Request beat
   typedef struct packed {
      logic [VALUE_FIELD_BITS-1:0] value;
      logic [WIDTH_BITS-1:0]       min_width;
      logic                        zero_pad;
   } req_type;

   // Response beat
   typedef struct packed {
      logic [CHAR_BITS-1:0] char_code;
      logic                 last;
   } rsp_type;

   // Decimal digits needed for the largest magnitude, 2^(bits-1)
   function automatic int num_digits(int bits);
      longint v;
      int     n;
      v = longint'(1) << (bits - 1);
      n = 0;
      do begin
         v = v / 10;
         n = n + 1;
      end while (v != 0);
      return n;
   endfunction

endpackage

/* rtl/zpdf_bcd_pipe.sv */
// Conversion pipeline: sign split, double dabble binary to BCD over several
// stages, then digit count and padding count. Depends on zpdf_pkg.
module zpdf_bcd_pipe #(
   parameter int VALUE_BITS = zpdf_pkg::DEF_VALUE_BITS,
   parameter int MAX_WIDTH  = zpdf_pkg::DEF_MAX_WIDTH,
   localparam int DIGITS    = zpdf_pkg::num_digits(VALUE_BITS),
   localparam int BCD_BITS  = 4 * DIGITS,
   localparam int CNT_BITS  = $clog2(DIGITS + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_take,
   input  zpdf_pkg::req_type               in_data,
   output logic                            in_ready,
   input  logic                            out_take,
   output logic                            out_valid,
   output logic [BCD_BITS-1:0]             out_bcd,
   output logic [CNT_BITS-1:0]             out_ndig,
   output logic [zpdf_pkg::WIDTH_BITS-1:0] out_pad_cnt,
   output logic                            out_neg
);

   localparam int STEP  = zpdf_pkg::BITS_PER_STAGE;
   localparam int NCONV = (VALUE_BITS + STEP - 1) / STEP;
   localparam int WB    = zpdf_pkg::WIDTH_BITS;

   typedef struct packed {
      logic [BCD_BITS-1:0]   bcd;
      logic [VALUE_BITS-1:0] mag;
      logic                  neg;
      logic [WB-1:0]         width;
      logic                  pad;
   } stage_type;

   // One stage's worth of double dabble shifts, starting at shift number base
   function automatic stage_type conv_step(stage_type s, int base);
      stage_type r;
      r = s;
      for (int j = 0; j < STEP; j++) begin
         if (base + j < VALUE_BITS) begin
            for (int d = 0; d < DIGITS; d++) begin
               if (r.bcd[4*d +: 4] >= 4'd5) begin
                  r.bcd[4*d +: 4] = r.bcd[4*d +: 4] + 4'd3;
               end
            end
            {r.bcd, r.mag} = {r.bcd[BCD_BITS-2:0], r.mag, 1'b0};
         end
      end
      return r;
   endfunction

   stage_type             stg_ff  [0:NCONV];
   stage_type             stg_nxt [1:NCONV];
   stage_type             in_stage;
   logic [NCONV:0]        vld_ff;
   logic [NCONV:0]        rdy;
   logic                  cnt_vld_ff;
   logic                  cnt_rdy;
   logic [BCD_BITS-1:0]   cnt_bcd_ff;
   logic [CNT_BITS-1:0]   cnt_ndig_ff;
   logic [CNT_BITS-1:0]   cnt_ndig_in;
   logic [WB-1:0]         cnt_pad_ff;
   logic [WB-1:0]         cnt_pad_in;
   logic                  cnt_neg_ff;
   logic [VALUE_BITS-1:0] raw;

   // Input stage: take the magnitude, clamp the width
   assign raw = in_data.value[VALUE_BITS-1:0];
   always_comb begin
      in_stage.bcd   = '0;
      in_stage.neg   = raw[VALUE_BITS-1];
      in_stage.mag   = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
      in_stage.width = (in_data.min_width > WB'(MAX_WIDTH)) ? WB'(MAX_WIDTH)
                                                            : in_data.min_width;
      in_stage.pad   = in_data.zero_pad;
   end

   // Conversion stages
   for (genvar c = 1; c <= NCONV; c++) begin : g_conv
      assign stg_nxt[c] = conv_step(stg_ff[c-1], (c - 1) * STEP);
   end

   // Digit count on the magnitude, zero counts as one digit; then the padding count
   always_comb begin
      cnt_ndig_in = CNT_BITS'(1);
      for (int d = 1; d < DIGITS; d++) begin
         if (stg_ff[NCONV].bcd[4*d +: 4] != 4'd0) begin
            cnt_ndig_in = CNT_BITS'(d + 1);
         end
      end
      if (stg_ff[NCONV].pad && (stg_ff[NCONV].width > WB'(cnt_ndig_in))) begin
         cnt_pad_in = stg_ff[NCONV].width - WB'(cnt_ndig_in);
      end else begin
         cnt_pad_in = '0;
      end
   end

   // Backpressure: a stage moves when it is empty or the next one moves
   assign cnt_rdy = !cnt_vld_ff || out_take;
   always_comb begin
      rdy[NCONV] = !vld_ff[NCONV] || cnt_rdy;
      for (int i = NCONV - 1; i >= 0; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i+1];
      end
   end
   assign in_ready = rdy[0];

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         cnt_vld_ff <= 1'b0;
      end else begin
         if (rdy[0]) begin
            vld_ff[0] <= in_take;
         end
         for (int c = 1; c <= NCONV; c++) begin
            if (rdy[c]) begin
               vld_ff[c] <= vld_ff[c-1];
            end
         end
         if (cnt_rdy) begin
            cnt_vld_ff <= vld_ff[NCONV];
         end
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (rdy[0] && in_take) begin
         stg_ff[0] <= in_stage;
      end
      for (int c = 1; c <= NCONV; c++) begin
         if (rdy[c] && vld_ff[c-1]) begin
            stg_ff[c] <= stg_nxt[c];
         end
      end
      if (cnt_rdy && vld_ff[NCONV]) begin
         cnt_bcd_ff  <= stg_ff[NCONV].bcd;
         cnt_ndig_ff <= cnt_ndig_in;
         cnt_pad_ff  <= cnt_pad_in;
         cnt_neg_ff  <= stg_ff[NCONV].neg;
      end
   end

   assign out_valid   = cnt_vld_ff;
   assign out_bcd     = cnt_bcd_ff;
   assign out_ndig    = cnt_ndig_ff;
   assign out_pad_cnt = cnt_pad_ff;
   assign out_neg     = cnt_neg_ff;

endmodule

/* rtl/zero_padded_decimal_formatter.sv */
// Top level of the zero padded decimal formatter: conversion pipeline plus
// the character emitter. Depends on zpdf_pkg and zpdf_bcd_pipe.
//
// Usage:
//   A number is accepted on a clock edge with start high and busy low; the
//   request beat carries value, min_width and zero_pad.
//   The text comes out on rsp_data one character per cycle, marked by
//   rsp_valid, the final character with last set: a minus sign for negative
//   values, then '0' padding up to min_width digits when zero_pad is set
//   (width capped at MAX_WIDTH), then the digits, most significant first.
//   Path: the first character appears once the request has passed the input
//   register, the double dabble pipeline of 8 shifts per stage, the digit
//   count register and the emitter state register.
//   Throughput: one character per cycle; a number has 1 to 64 characters and
//   the next number, if already waiting in the pipeline, follows without a gap.
//   Further numbers queue in the pipeline stages; busy rises once they are
//   all full behind the emitter.
//   The receiver cannot stall: every response beat is taken when shown.
//   Reset empties the pipeline and the emitter; busy is low afterwards.
module zero_padded_decimal_formatter #(
   parameter int MAX_WIDTH  = zpdf_pkg::DEF_MAX_WIDTH,
   parameter int VALUE_BITS = zpdf_pkg::DEF_VALUE_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  zpdf_pkg::req_type req_data,
   output logic              rsp_valid,
   output zpdf_pkg::rsp_type rsp_data
);

   localparam int DIGITS   = zpdf_pkg::num_digits(VALUE_BITS);
   localparam int BCD_BITS = 4 * DIGITS;
   localparam int CNT_BITS = $clog2(DIGITS + 1);
   localparam int IDX_BITS = $clog2(DIGITS);
   localparam int WB       = zpdf_pkg::WIDTH_BITS;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SIGN  = 4'b0010,
      ST_PAD   = 4'b0100,
      ST_DIGIT = 4'b1000
   } state_type;

   state_type           state_ff, state_in, load_state;
   logic                in_ready;
   logic                cv_valid;
   logic [BCD_BITS-1:0] cv_bcd;
   logic [CNT_BITS-1:0] cv_ndig;
   logic [WB-1:0]       cv_pad;
   logic                cv_neg;
   logic                load;
   logic                final_digit;
   logic [BCD_BITS-1:0] bcd_ff, bcd_in;
   logic [CNT_BITS-1:0] dig_left_ff, dig_left_in;
   logic [WB-1:0]       pad_left_ff, pad_left_in;
   logic [CNT_BITS-1:0] dig_sel;
   logic [3:0]          digit_arr [DIGITS];

   assign busy = !in_ready;

   zpdf_bcd_pipe #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_WIDTH  (MAX_WIDTH)
   ) u_pipe (
      .clock       (clock),
      .reset       (reset),
      .in_take     (start && in_ready),
      .in_data     (req_data),
      .in_ready    (in_ready),
      .out_take    (load),
      .out_valid   (cv_valid),
      .out_bcd     (cv_bcd),
      .out_ndig    (cv_ndig),
      .out_pad_cnt (cv_pad),
      .out_neg     (cv_neg)
   );

   // Emitter load: when idle or on the final digit of the current number
   assign final_digit = (state_ff == ST_DIGIT) && (dig_left_ff == CNT_BITS'(1));
   assign load        = cv_valid && ((state_ff == ST_IDLE) || final_digit);

   always_comb begin
      if (cv_neg) begin
         load_state = ST_SIGN;
      end else if (cv_pad != '0) begin
         load_state = ST_PAD;
      end else begin
         load_state = ST_DIGIT;
      end
   end

   // Emitter sequencing
   always_comb begin
      state_in    = state_ff;
      bcd_in      = bcd_ff;
      dig_left_in = dig_left_ff;
      pad_left_in = pad_left_ff;
      case (state_ff)
         ST_SIGN: begin
            state_in = (pad_left_ff != '0) ? ST_PAD : ST_DIGIT;
         end
         ST_PAD: begin
            pad_left_in = pad_left_ff - 1'b1;
            if (pad_left_ff == WB'(1)) begin
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            dig_left_in = dig_left_ff - 1'b1;
            if (final_digit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (load) begin
         state_in    = load_state;
         bcd_in      = cv_bcd;
         dig_left_in = cv_ndig;
         pad_left_in = cv_pad;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      bcd_ff      <= bcd_in;
      dig_left_ff <= dig_left_in;
      pad_left_ff <= pad_left_in;
   end

   // Response beat
   for (genvar d = 0; d < DIGITS; d++) begin : g_digit
      assign digit_arr[d] = bcd_ff[4*d +: 4];
   end
   assign dig_sel = dig_left_ff - 1'b1;

   always_comb begin
      rsp_valid          = (state_ff != ST_IDLE);
      rsp_data.last      = final_digit;
      case (state_ff)
         ST_SIGN:  rsp_data.char_code = zpdf_pkg::ASCII_MINUS;
         ST_PAD:   rsp_data.char_code = zpdf_pkg::ASCII_ZERO;
         ST_DIGIT: rsp_data.char_code = zpdf_pkg::ASCII_ZERO
                                        + {4'b0000, digit_arr[dig_sel[IDX_BITS-1:0]]};
         default:  rsp_data.char_code = zpdf_pkg::ASCII_ZERO;
      endcase
   end

endmodule

/* rtl/zpdf_checker.sv */
// Port level checks for the zero padded decimal formatter, bound to the top.
// Depends on zpdf_pkg and zero_padded_decimal_formatter.
module zpdf_checker (
   input logic              clock,
   input logic              reset,
   input logic              busy,
   input logic              rsp_valid,
   input zpdf_pkg::rsp_type rsp_data
);

   logic is_digit;
   assign is_digit = (rsp_data.char_code >= zpdf_pkg::ASCII_ZERO)
                  && (rsp_data.char_code <= zpdf_pkg::ASCII_ZERO + 8'd9);

   // A number's text has no gaps
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |=> rsp_valid)
      else $error("gap inside a number's text");

   // A minus sign is followed by a padding zero or a digit
   a_after_minus: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.char_code == zpdf_pkg::ASCII_MINUS)
      |=> rsp_valid && is_digit)
      else $error("minus sign not followed by a digit");

   // The final character is always a decimal digit
   a_last_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |-> is_digit)
      else $error("final character is not a digit");

   // Reset leaves the block empty and ready
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && !busy)
      else $error("block not empty after reset");

endmodule

bind zero_padded_decimal_formatter zpdf_checker u_checker (.*);

/* test/tb.sv */
// Self-checking testbench for zero_padded_decimal_formatter: directed table then random numbers,
// every character checked against typed text or an in-bench decimal formatter.
// Depends on zpdf_pkg and the formatter RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT    = 2000;
   localparam int ITEMS_PER_PASS = 136;
   localparam int TAIL_CYCLES    = 20;

   typedef struct {
      logic [31:0] value;
      int          width;
      bit          pad;
      string       text;   // typed expectation; empty means use the formatter model
   } directed_row_type;

   localparam int NUM_ROWS = 21;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   zpdf_pkg::req_type req_data;
   logic              rsp_valid;
   zpdf_pkg::rsp_type rsp_data;

   string             row_text;
   zpdf_pkg::rsp_type pending_chars[$];
   int                mismatches;
   int                stall_cycles;

   directed_row_type directed_rows [NUM_ROWS] = '{
      '{32'd0,          0,  1'b0, "0"},
      '{32'd1,          0,  1'b0, "1"},
      '{-32'sd1,        0,  1'b0, "-1"},
      '{32'h7FFFFFFF,   0,  1'b0, "2147483647"},
      '{32'h80000000,   0,  1'b0, "-2147483648"},
      '{32'd5,          3,  1'b1, "005"},
      '{-32'sd42,       5,  1'b1, "-00042"},
      '{32'd123,        63, 1'b0, "123"},
      '{32'd12345,      3,  1'b1, "12345"},
      '{32'd7,          1,  1'b1, "7"},
      '{32'd0,          1,  1'b1, "0"},
      '{32'd0,          2,  1'b1, "00"},
      '{32'd1000000000, 10, 1'b1, "1000000000"},
      '{-32'sd7,        2,  1'b1, "-07"},
      '{32'd999999999,  9,  1'b1, "999999999"},
      '{-32'sd1,        63, 1'b0, "-1"},
      '{32'd0,          63, 1'b1, ""},
      '{32'h80000000,   63, 1'b1, ""},
      '{32'h7FFFFFFF,   63, 1'b1, ""},
      '{32'h55555555,   42, 1'b1, ""},
      '{32'hAAAAAAAA,   21, 1'b1, ""}
   };

   zero_padded_decimal_formatter u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void push_char(input logic [7:0] code, input logic is_last);
      zpdf_pkg::rsp_type c;
      c.char_code = code;
      c.last      = is_last;
      pending_chars.push_back(c);
   endfunction

   // Expected text of one number: sign, zero padding, then magnitude digits
   function automatic void format_number(input zpdf_pkg::req_type r);
      logic        neg;
      logic [32:0] mag;
      logic [3:0]  digs [0:15];
      int          ndig;
      int          width;
      int          pad_cnt;
      int          total;
      int          k;
      neg   = r.value[31];
      mag   = neg ? (33'd0 - {r.value[31], r.value}) : {1'b0, r.value};
      width = int'(r.min_width);
      if (width > zpdf_pkg::DEF_MAX_WIDTH) width = zpdf_pkg::DEF_MAX_WIDTH;
      ndig = 0;
      do begin
         digs[ndig] = 4'(mag % 10);
         mag        = mag / 10;
         ndig++;
      end while (mag != 0);
      pad_cnt = (r.zero_pad && width > ndig) ? width - ndig : 0;
      total   = int'(neg) + pad_cnt + ndig;
      k       = 0;
      if (neg) begin
         k++;
         push_char(zpdf_pkg::ASCII_MINUS, k == total);
      end
      for (int i = 0; i < pad_cnt; i++) begin
         k++;
         push_char(zpdf_pkg::ASCII_ZERO, k == total);
      end
      for (int i = ndig - 1; i >= 0; i--) begin
         k++;
         push_char(zpdf_pkg::ASCII_ZERO + 8'(digs[i]), k == total);
      end
   endfunction

   // Accepted beats in, characters checked out, stall watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            if (row_text.len() != 0) begin
               for (int i = 0; i < row_text.len(); i++)
                  push_char(row_text[i], i == row_text.len() - 1);
            end else begin
               format_number(req_data);
            end
         end
         if (rsp_valid) begin
            if (pending_chars.size() == 0) begin
               mismatches++;
               $display("%0t unexpected character: expected none, actual %h last %b",
                        $time, rsp_data.char_code, rsp_data.last);
            end else begin
               if (rsp_data.char_code !== pending_chars[0].char_code) begin
                  mismatches++;
                  $display("%0t char_code: expected %h, actual %h",
                           $time, pending_chars[0].char_code, rsp_data.char_code);
               end
               if (rsp_data.last !== pending_chars[0].last) begin
                  mismatches++;
                  $display("%0t last: expected %b, actual %b",
                           $time, pending_chars[0].last, rsp_data.last);
               end
               void'(pending_chars.pop_front());
            end
         end
         if ((start && !busy) || rsp_valid) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   // Hold start high until the beat is taken
   task automatic send_number(input zpdf_pkg::req_type r, input string text);
      start    <= 1'b1;
      req_data <= r;
      row_text <= text;
      do @(posedge clock); while (busy);
   endtask

   task automatic sender_gap(input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Stop sending until the whole backlog of characters has drained
   task automatic drain_pause();
      start <= 1'b0;
      do @(posedge clock); while (pending_chars.size() != 0);
   endtask

   function automatic zpdf_pkg::req_type random_request();
      zpdf_pkg::req_type r;
      longint            p;
      int                sel;
      sel = $urandom_range(9);
      if (sel <= 2) begin
         r.value = $urandom;
      end else if (sel <= 4) begin
         r.value = $urandom_range(99);
         if ($urandom_range(1)) r.value = -r.value;
      end else if (sel == 5) begin
         case ($urandom_range(5))
            0:       r.value = 32'h7FFFFFFF;
            1:       r.value = 32'h80000000;
            2:       r.value = 32'h80000001;
            3:       r.value = 32'hFFFFFFFF;
            4:       r.value = 32'd0;
            default: r.value = 32'd1;
         endcase
      end else if (sel <= 7) begin
         // decade boundaries: 10^k and 10^k - 1
         p = 1;
         repeat ($urandom_range(9)) p = p * 10;
         r.value = 32'(p - longint'($urandom_range(1)));
         if ($urandom_range(1)) r.value = -r.value;
      end else begin
         r.value = $urandom_range(999999);
         if ($urandom_range(1)) r.value = -r.value;
      end
      r.min_width = ($urandom_range(4) != 0) ? 6'($urandom_range(12)) : 6'($urandom_range(63));
      r.zero_pad  = 1'($urandom_range(1));
      return r;
   endfunction

   initial begin
      int                idle_pct [3];
      zpdf_pkg::req_type r;
      reset        = 1'b1;
      start        = 1'b0;
      req_data     = '0;
      row_text     = "";
      mismatches   = 0;
      stall_cycles = 0;
      idle_pct     = '{36, 71, 0};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table
      foreach (directed_rows[i]) begin
         r.value     = directed_rows[i].value;
         r.min_width = 6'(directed_rows[i].width);
         r.zero_pad  = directed_rows[i].pad;
         send_number(r, directed_rows[i].text);
         sender_gap(idle_pct[0]);
      end
      drain_pause();

      // Random numbers, one pass per idling profile
      for (int pass = 0; pass < 3; pass++) begin
         for (int n = 0; n < ITEMS_PER_PASS; n++) begin
            send_number(random_request(), "");
            sender_gap(idle_pct[pass]);
         end
         drain_pause();
      end

      start <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_chars.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

/* sim.f */
rtl/zpdf_pkg.sv
rtl/zpdf_bcd_pipe.sv
rtl/zero_padded_decimal_formatter.sv
rtl/zpdf_checker.sv
test/tb.sv
